// ===== rtl/bld_pkg.sv =====
package bld_pkg;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_CONTROL0  = 3'd0,
    REG_CONTROL1  = 3'd1,
    REG_A_MODULO  = 3'd2,
    REG_B_MODULO  = 3'd3,
    REG_C_MODULO  = 3'd4,
    REG_A_PATTERN = 3'd5,
    REG_B_TEXTURE = 3'd6
  } bld_reg_e;

  // input word kinds
  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } bld_op_e;

  localparam logic [15:0] A_PATTERN_RESET = 16'h8000;
  localparam logic [15:0] B_TEXTURE_RESET = 16'hFFFF;
  localparam int unsigned DOT_WRAP_STEP   = 2;

  // control0 fields
  localparam int unsigned C0_SHIFT_LSB = 12;
  localparam int unsigned C0_D_ENABLE  = 8;
  // control1 fields
  localparam int unsigned C1_ROT_LSB   = 12;
  localparam int unsigned C1_SIGN      = 6;
  localparam int unsigned C1_SUD       = 4;
  localparam int unsigned C1_SUL       = 3;
  localparam int unsigned C1_AUL       = 2;
  localparam int unsigned C1_ONE_DOT   = 1;

  typedef struct packed {
    logic [15:0]        control0;
    logic [15:0]        control1;
    logic signed [15:0] a_modulo;
    logic signed [15:0] b_modulo;
    logic signed [15:0] c_modulo;
    logic [15:0]        a_pattern;
    logic [15:0]        b_texture;
  } bld_cfg_t;

  function automatic logic [15:0] bld_minterm(input logic [15:0] a, input logic [15:0] b,
                                              input logic [15:0] c, input logic [7:0] mt);
    logic [15:0] r;
    r = '0;
    for (int i = 0; i < 16; i++) begin
      r[i] = mt[{a[i], b[i], c[i]}];
    end
    return r;
  endfunction

  function automatic logic [15:0] bld_rotr(input logic [15:0] w, input logic [3:0] rot);
    logic [31:0] dbl;
    dbl = {w, w} >> rot;
    return dbl[15:0];
  endfunction

endpackage

// ===== rtl/bld_cfg_regs.sv =====
module bld_cfg_regs (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  output bld_pkg::bld_cfg_t  cfg_o
);
  import bld_pkg::*;

  bld_cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (bld_reg_e'(cfg_index_i))
        REG_CONTROL0:  cfg_d.control0  = cfg_data_i;
        REG_CONTROL1:  cfg_d.control1  = cfg_data_i;
        REG_A_MODULO:  cfg_d.a_modulo  = cfg_data_i;
        REG_B_MODULO:  cfg_d.b_modulo  = cfg_data_i;
        REG_C_MODULO:  cfg_d.c_modulo  = cfg_data_i;
        REG_A_PATTERN: cfg_d.a_pattern = cfg_data_i;
        REG_B_TEXTURE: cfg_d.b_texture = cfg_data_i;
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q           <= '0;
      cfg_q.a_pattern <= A_PATTERN_RESET;
      cfg_q.b_texture <= B_TEXTURE_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== rtl/bld_step.sv =====
module bld_step #(
  parameter int unsigned ADDR_BITS   = 21,
  parameter int unsigned LENGTH_BITS = 10
) (
  input  bld_pkg::bld_cfg_t         cfg_i,
  // current line state
  input  logic [ADDR_BITS-1:0]      c_ptr_i,
  input  logic [ADDR_BITS-1:0]      d_ptr_i,
  input  logic [15:0]               err_i,
  input  logic                      sign_i,
  input  logic [3:0]                shift_i,
  input  logic [15:0]               tex_i,
  input  logic                      one_dot_i,
  input  logic [LENGTH_BITS:0]      remain_i,
  input  logic                      zero_i,
  input  logic                      busy_i,
  // input word
  input  logic                      op_i,
  input  logic [ADDR_BITS-1:0]      c_start_i,
  input  logic [ADDR_BITS-1:0]      d_start_i,
  input  logic signed [15:0]        error_start_i,
  input  logic [LENGTH_BITS-1:0]    length_i,
  input  logic [15:0]               c_word_i,
  // next line state
  output logic [ADDR_BITS-1:0]      c_ptr_o,
  output logic [ADDR_BITS-1:0]      d_ptr_o,
  output logic [15:0]               err_o,
  output logic                      sign_o,
  output logic [3:0]                shift_o,
  output logic [15:0]               tex_o,
  output logic                      one_dot_o,
  output logic [LENGTH_BITS:0]      remain_o,
  output logic                      zero_o,
  output logic                      busy_o,
  // result word
  output logic                      result_o,
  output logic [15:0]               wdata_o,
  output logic                      last_o
);
  import bld_pkg::*;

  logic                   sud, x_move, x_left, y_move, y_up, x_wrap;
  logic [15:0]            a_word, b_word;
  logic signed [15:0]     err_inc;
  logic [15:0]            err_next;
  logic [ADDR_BITS-1:0]   cmod_ext, x_delta, y_delta, delta;
  logic [3:0]             shift_next;
  logic [LENGTH_BITS:0]   remain_next;

  // octant decode: one x move and one y move at most per dot
  assign sud    = cfg_i.control1[C1_SUD];
  assign x_move = sud ? 1'b1 : !sign_i;
  assign x_left = sud ? cfg_i.control1[C1_AUL] : cfg_i.control1[C1_SUL];
  assign y_move = sud ? !sign_i : 1'b1;
  assign y_up   = sud ? cfg_i.control1[C1_SUL] : cfg_i.control1[C1_AUL];

  assign x_wrap = x_left ? (shift_i == 4'd0) : (shift_i == 4'd15);

  always_comb begin
    shift_next = shift_i;
    x_delta    = '0;
    if (x_move) begin
      shift_next = x_left ? shift_i - 4'd1 : shift_i + 4'd1;
      if (x_wrap) begin
        x_delta = x_left ? '0 - ADDR_BITS'(DOT_WRAP_STEP) : ADDR_BITS'(DOT_WRAP_STEP);
      end
    end
  end

  assign cmod_ext = ADDR_BITS'(cfg_i.c_modulo);
  assign y_delta  = !y_move ? '0 : (y_up ? '0 - cmod_ext : cmod_ext);
  assign delta    = x_delta + y_delta;

  // dot pattern, texture and minterm
  always_comb begin
    a_word = cfg_i.a_pattern >> shift_i;
    if (cfg_i.control1[C1_ONE_DOT] && one_dot_i) begin
      a_word = '0;
    end
  end
  assign b_word  = {16{tex_i[0]}};
  assign wdata_o = bld_minterm(a_word, b_word, c_word_i, cfg_i.control0[7:0]);

  assign err_inc     = sign_i ? cfg_i.b_modulo : cfg_i.a_modulo;
  assign err_next    = err_i + err_inc;
  assign remain_next = remain_i - (LENGTH_BITS+1)'(1);
  assign last_o      = (remain_next == '0);

  always_comb begin
    c_ptr_o   = c_ptr_i;
    d_ptr_o   = d_ptr_i;
    err_o     = err_i;
    sign_o    = sign_i;
    shift_o   = shift_i;
    tex_o     = tex_i;
    one_dot_o = one_dot_i;
    remain_o  = remain_i;
    zero_o    = zero_i;
    busy_o    = busy_i;
    result_o  = 1'b0;
    unique case (bld_op_e'(op_i))
      OP_START: begin
        c_ptr_o   = c_start_i;
        d_ptr_o   = d_start_i;
        err_o     = error_start_i;
        sign_o    = cfg_i.control1[C1_SIGN];
        shift_o   = cfg_i.control0[C0_SHIFT_LSB +: 4];
        tex_o     = bld_rotr(cfg_i.b_texture, cfg_i.control1[C1_ROT_LSB +: 4]);
        one_dot_o = 1'b0;
        remain_o  = (length_i == '0) ? {1'b1, {LENGTH_BITS{1'b0}}}
                                     : {1'b0, length_i};
        zero_o    = 1'b1;
        busy_o    = 1'b1;
      end
      OP_STEP: begin
        if (busy_i) begin
          result_o  = 1'b1;
          c_ptr_o   = c_ptr_i + delta;
          d_ptr_o   = d_ptr_i + delta;
          err_o     = err_next;
          sign_o    = err_next[15];
          shift_o   = shift_next;
          tex_o     = {tex_i[14:0], tex_i[15]};
          one_dot_o = !y_move;
          remain_o  = remain_next;
          zero_o    = zero_i && (wdata_o == '0);
          busy_o    = !last_o;
        end
      end
      default: begin
        result_o = 1'b0;
      end
    endcase
  end

endmodule

// ===== rtl/blitter_line_draw_stepper.sv =====
// channel  | direction | handshake                 | word
// ---------+-----------+---------------------------+-------------------------------------
// cfg      | in        | cfg_valid_i / cfg_ready_o | register index, 16-bit data
// in       | in        | in_valid_i  / in_stall_o  | op, start pointers, error, length, c word
// out      | out       | out_valid_o / out_stall_i | write address/data/enable, read addr, flags
//
// one input word per cycle while in_stall_o is low; a step word's result appears in the cycle after acceptance
// the whole dot step (minterm, error add, pointer add) is one combinational pass
// between the line state registers and the output register
// in_stall_o rises only while a result is held and out_stall_i is high
// reset clears the line state (idle), loads register defaults; no clearing pass
module blitter_line_draw_stepper #(
  parameter int unsigned ADDR_BITS   = 21,
  parameter int unsigned LENGTH_BITS = 10
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration write channel
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [2:0]             cfg_index_i,
  input  logic [15:0]            cfg_data_i,
  // input words
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   op_i,
  input  logic [ADDR_BITS-1:0]   c_start_i,
  input  logic [ADDR_BITS-1:0]   d_start_i,
  input  logic signed [15:0]     error_start_i,
  input  logic [LENGTH_BITS-1:0] length_i,
  input  logic [15:0]            c_word_i,
  // result words
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [ADDR_BITS-1:0]   write_address_o,
  output logic [15:0]            write_data_o,
  output logic                   write_enable_o,
  output logic [ADDR_BITS-1:0]   next_read_address_o,
  output logic                   last_o,
  output logic                   all_zero_o
);
  import bld_pkg::*;

  bld_cfg_t cfg;

  // line state
  logic [ADDR_BITS-1:0]   c_ptr_q, c_ptr_d, d_ptr_q, d_ptr_d;
  logic [15:0]            err_q, err_d, tex_q, tex_d;
  logic                   sign_q, sign_d, one_dot_q, one_dot_d;
  logic                   zero_q, zero_d, busy_q, busy_d;
  logic [3:0]             shift_q, shift_d;
  logic [LENGTH_BITS:0]   remain_q, remain_d;

  // step outputs
  logic                   has_result, step_last;
  logic [15:0]            step_wdata;

  // output register
  logic                   out_valid_q, out_valid_d;
  logic [ADDR_BITS-1:0]   waddr_q, raddr_q;
  logic [15:0]            wdata_q;
  logic                   wen_q, last_q, zero_out_q;

  logic                   in_accept, load_out;

  bld_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  bld_step #(
    .ADDR_BITS   (ADDR_BITS),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_step (
    .cfg_i         (cfg),
    .c_ptr_i       (c_ptr_q),
    .d_ptr_i       (d_ptr_q),
    .err_i         (err_q),
    .sign_i        (sign_q),
    .shift_i       (shift_q),
    .tex_i         (tex_q),
    .one_dot_i     (one_dot_q),
    .remain_i      (remain_q),
    .zero_i        (zero_q),
    .busy_i        (busy_q),
    .op_i          (op_i),
    .c_start_i     (c_start_i),
    .d_start_i     (d_start_i),
    .error_start_i (error_start_i),
    .length_i      (length_i),
    .c_word_i      (c_word_i),
    .c_ptr_o       (c_ptr_d),
    .d_ptr_o       (d_ptr_d),
    .err_o         (err_d),
    .sign_o        (sign_d),
    .shift_o       (shift_d),
    .tex_o         (tex_d),
    .one_dot_o     (one_dot_d),
    .remain_o      (remain_d),
    .zero_o        (zero_d),
    .busy_o        (busy_d),
    .result_o      (has_result),
    .wdata_o       (step_wdata),
    .last_o        (step_last)
  );

  // accept whenever the output register is empty or being drained
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign load_out   = in_accept && has_result;

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // line state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_ptr_q     <= '0;
      d_ptr_q     <= '0;
      err_q       <= '0;
      sign_q      <= 1'b0;
      shift_q     <= '0;
      tex_q       <= '0;
      one_dot_q   <= 1'b0;
      remain_q    <= '0;
      zero_q      <= 1'b1;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_accept) begin
        c_ptr_q   <= c_ptr_d;
        d_ptr_q   <= d_ptr_d;
        err_q     <= err_d;
        sign_q    <= sign_d;
        shift_q   <= shift_d;
        tex_q     <= tex_d;
        one_dot_q <= one_dot_d;
        remain_q  <= remain_d;
        zero_q    <= zero_d;
        busy_q    <= busy_d;
      end
    end
  end

  // result payload, write address is the d pointer before the step
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      waddr_q    <= d_ptr_q;
      wdata_q    <= step_wdata;
      wen_q      <= cfg.control0[C0_D_ENABLE];
      raddr_q    <= c_ptr_d;
      last_q     <= step_last;
      zero_out_q <= zero_d;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign write_address_o     = waddr_q;
  assign write_data_o        = wdata_q;
  assign write_enable_o      = wen_q;
  assign next_read_address_o = raddr_q;
  assign last_o              = last_q;
  assign all_zero_o          = zero_out_q;

endmodule

// ===== sim/line_write_ledger_pkg.sv =====
package line_write_ledger_pkg;

  import bld_pkg::*;

  localparam int unsigned ADDR_W = 21;
  localparam int unsigned LEN_W  = 10;

  typedef struct packed {
    logic [ADDR_W-1:0] write_address;
    logic [15:0]       write_data;
    logic              write_enable;
    logic [ADDR_W-1:0] next_read_address;
    logic              last;
    logic              all_zero;
  } dot_write_t;

  // tracks the line stepper state and the d writes it still owes
  class line_write_ledger;

    logic [15:0]        control0, control1, a_pattern, b_texture;
    logic signed [15:0] a_modulo, b_modulo, c_modulo;

    logic [ADDR_W-1:0]  c_ptr, d_ptr;
    logic [15:0]        err_term, texture;
    logic [3:0]         dot_shift;
    logic [LEN_W:0]     remaining;
    logic               sign_flag, one_dot, zero_flag, busy;

    dot_write_t         due_writes[$];
    int unsigned        errors;

    function new();
      control0  = '0;
      control1  = '0;
      a_modulo  = '0;
      b_modulo  = '0;
      c_modulo  = '0;
      a_pattern = A_PATTERN_RESET;
      b_texture = B_TEXTURE_RESET;
      c_ptr     = '0;
      d_ptr     = '0;
      err_term  = '0;
      texture   = '0;
      dot_shift = '0;
      remaining = '0;
      sign_flag = 1'b0;
      one_dot   = 1'b0;
      zero_flag = 1'b1;
      busy      = 1'b0;
      errors    = 0;
    endfunction

    function void write_reg(bld_reg_e idx, logic [15:0] data);
      case (idx)
        REG_CONTROL0:  control0  = data;
        REG_CONTROL1:  control1  = data;
        REG_A_MODULO:  a_modulo  = data;
        REG_B_MODULO:  b_modulo  = data;
        REG_C_MODULO:  c_modulo  = data;
        REG_A_PATTERN: a_pattern = data;
        REG_B_TEXTURE: b_texture = data;
        default: ;
      endcase
    endfunction

    function int pending();
      return due_writes.size();
    endfunction

    function void shift_pointers(int delta);
      logic [ADDR_W-1:0] step;
      step  = ADDR_W'(delta);
      c_ptr = c_ptr + step;
      d_ptr = d_ptr + step;
    endfunction

    // one dot sideways; crossing a word boundary moves both pointers a word
    function void move_x(logic left);
      if (left) begin
        if (dot_shift == 4'd0) begin
          dot_shift = 4'd15;
          shift_pointers(-int'(DOT_WRAP_STEP));
        end else begin
          dot_shift = dot_shift - 4'd1;
        end
      end else begin
        if (dot_shift == 4'd15) begin
          dot_shift = 4'd0;
          shift_pointers(int'(DOT_WRAP_STEP));
        end else begin
          dot_shift = dot_shift + 4'd1;
        end
      end
    endfunction

    function void move_y(logic up);
      int stride;
      stride = int'(c_modulo);
      shift_pointers(up ? -stride : stride);
      one_dot = 1'b0;
    endfunction

    // sum of the minterm products selected by mt
    function logic [15:0] mix(logic [15:0] a, logic [15:0] b, logic [15:0] c,
                              logic [7:0] mt);
      logic [15:0] r;
      r = '0;
      for (int k = 0; k < 8; k++) begin
        if (mt[k]) r |= (k[2] ? a : ~a) & (k[1] ? b : ~b) & (k[0] ? c : ~c);
      end
      return r;
    endfunction

    // returns 1 when the word started a line or produced a d write
    function bit note_word(bld_op_e op, logic [ADDR_W-1:0] c_start,
                           logic [ADDR_W-1:0] d_start, logic [15:0] err_start,
                           logic [LEN_W-1:0] len, logic [15:0] c_word);
      logic [15:0] a, b, d;
      dot_write_t  w;
      if (op == OP_START) begin
        c_ptr     = c_start;
        d_ptr     = d_start;
        err_term  = err_start;
        sign_flag = control1[C1_SIGN];
        dot_shift = control0[C0_SHIFT_LSB +: 4];
        texture   = b_texture;
        for (int i = 0; i < control1[C1_ROT_LSB +: 4]; i++) texture = {texture[0], texture[15:1]};
        one_dot   = 1'b0;
        remaining = (len == '0) ? {1'b1, {LEN_W{1'b0}}} : {1'b0, len};
        zero_flag = 1'b1;
        busy      = 1'b1;
        return 1'b1;
      end
      if (!busy) return 1'b0;

      a = a_pattern >> dot_shift;
      b = {16{texture[0]}};
      if (control1[C1_ONE_DOT] && one_dot) a = '0;
      one_dot = 1'b1;
      d = mix(a, b, c_word, control0[7:0]);
      if (d != '0) zero_flag = 1'b0;
      w.write_address = d_ptr;

      if (!sign_flag) begin
        err_term = err_term + a_modulo;
        if (control1[C1_SUD]) move_y(control1[C1_SUL]);
        else move_x(control1[C1_SUL]);
      end else begin
        err_term = err_term + b_modulo;
      end
      if (control1[C1_SUD]) move_x(control1[C1_AUL]);
      else move_y(control1[C1_AUL]);
      sign_flag = err_term[15];

      texture   = {texture[14:0], texture[15]};
      remaining = remaining - 1'b1;
      if (remaining == '0) busy = 1'b0;

      w.write_data        = d;
      w.write_enable      = control0[C0_D_ENABLE];
      w.next_read_address = c_ptr;
      w.last              = (remaining == '0);
      w.all_zero          = zero_flag;
      due_writes.push_back(w);
      return 1'b1;
    endfunction

    function void check_write(dot_write_t got);
      dot_write_t want;
      if (due_writes.size() == 0) begin
        $error("d write at %0h with none due", got.write_address);
        errors++;
        return;
      end
      want = due_writes.pop_front();
      if (got.write_address !== want.write_address) begin
        $error("write_address: expected %0h, got %0h", want.write_address, got.write_address);
        errors++;
      end
      if (got.write_data !== want.write_data) begin
        $error("write_data: expected %0h, got %0h", want.write_data, got.write_data);
        errors++;
      end
      if (got.write_enable !== want.write_enable) begin
        $error("write_enable: expected %0b, got %0b", want.write_enable, got.write_enable);
        errors++;
      end
      if (got.next_read_address !== want.next_read_address) begin
        $error("next_read_address: expected %0h, got %0h",
               want.next_read_address, got.next_read_address);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0b, got %0b", want.last, got.last);
        errors++;
      end
      if (got.all_zero !== want.all_zero) begin
        $error("all_zero: expected %0b, got %0b", want.all_zero, got.all_zero);
        errors++;
      end
    endfunction

  endclass

endpackage

// ===== sim/testbench.sv =====
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  import bld_pkg::*;
  import line_write_ledger_pkg::*;

  // generous ceiling, far beyond the slowest clean run
  localparam int unsigned CYCLE_LIMIT = 200000;

  logic              clk_i  = 1'b0;
  logic              rst_ni = 1'b0;

  // config write channel
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [2:0]        cfg_index_i = '0;
  logic [15:0]       cfg_data_i  = '0;

  // input words
  logic              in_valid_i    = 1'b0;
  logic              in_stall_o;
  logic              op_i          = 1'b0;
  logic [ADDR_W-1:0] c_start_i     = '0;
  logic [ADDR_W-1:0] d_start_i     = '0;
  logic [15:0]       error_start_i = '0;
  logic [LEN_W-1:0]  length_i      = '0;
  logic [15:0]       c_word_i      = '0;

  // result words
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [ADDR_W-1:0] write_address_o;
  logic [15:0]       write_data_o;
  logic              write_enable_o;
  logic [ADDR_W-1:0] next_read_address_o;
  logic              last_o;
  logic              all_zero_o;

  line_write_ledger  ledger = new();

  // chance per cycle, in percent, that either side holds off
  int unsigned       send_gap_pct   = 38;
  int unsigned       recv_stall_pct = 49;
  int unsigned       taken_words    = 0;
  int unsigned       cycles         = 0;

  blitter_line_draw_stepper #(
    .ADDR_BITS  (ADDR_W),
    .LENGTH_BITS(LEN_W)
  ) i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .op_i               (op_i),
    .c_start_i          (c_start_i),
    .d_start_i          (d_start_i),
    .error_start_i      (error_start_i),
    .length_i           (length_i),
    .c_word_i           (c_word_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .write_address_o    (write_address_o),
    .write_data_o       (write_data_o),
    .write_enable_o     (write_enable_o),
    .next_read_address_o(next_read_address_o),
    .last_o             (last_o),
    .all_zero_o         (all_zero_o)
  );

  // 8 ns clock
  always #4 clk_i = ~clk_i;

  // watchdog: a hang anywhere ends the run as a failure
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // result side stalls at random, changed on the falling edge only
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // every word taken on the result side is checked against the oldest due write
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      ledger.check_write(dot_write_t'{write_address_o, write_data_o, write_enable_o,
                                      next_read_address_o, last_o, all_zero_o});
    end
  end

  // one register write; leaves valid high, the caller drops it
  task automatic write_reg(bld_reg_e idx, logic [15:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    ledger.write_reg(idx, data);
  endtask

  // writes the whole register set, only ever called once every due write has come back
  task automatic load_config(bld_cfg_t cfg);
    write_reg(REG_CONTROL0, cfg.control0);
    write_reg(REG_CONTROL1, cfg.control1);
    write_reg(REG_A_MODULO, cfg.a_modulo);
    write_reg(REG_B_MODULO, cfg.b_modulo);
    write_reg(REG_C_MODULO, cfg.c_modulo);
    write_reg(REG_A_PATTERN, cfg.a_pattern);
    write_reg(REG_B_TEXTURE, cfg.b_texture);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // one input word, with a random gap first; valid stays high after acceptance
  // so that back-to-back words never drop it in between
  task automatic send_word(bld_op_e op, logic [ADDR_W-1:0] c_start,
                           logic [ADDR_W-1:0] d_start, logic [15:0] err_start,
                           logic [LEN_W-1:0] len, logic [15:0] c_word);
    @(negedge clk_i);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    op_i          = op;
    c_start_i     = c_start;
    d_start_i     = d_start;
    error_start_i = err_start;
    length_i      = len;
    c_word_i      = c_word;
    in_valid_i    = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    if (ledger.note_word(op, c_start, d_start, err_start, len, c_word)) taken_words++;
  endtask

  // start word; the unused c word carries noise
  task automatic start_line(logic [ADDR_W-1:0] c_start, logic [ADDR_W-1:0] d_start,
                            logic [15:0] err_start, logic [LEN_W-1:0] len);
    send_word(OP_START, c_start, d_start, err_start, len, 16'($urandom));
  endtask

  // step word; the unused start fields carry noise
  task automatic step_dot(logic [15:0] c_word);
    send_word(OP_STEP, ADDR_W'($urandom), ADDR_W'($urandom), 16'($urandom),
              LEN_W'($urandom), c_word);
  endtask

  // sender holds off until every due write has come back, then lets the
  // result register settle before anything else happens
  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (ledger.pending() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  initial begin
    bld_cfg_t         cfg;
    int unsigned      goal;
    int unsigned      dots;
    logic [LEN_W-1:0] len;
    bit               paused;

    // reset once, released on a falling edge
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    // ---- directed part ----

    // step with no line loaded: dropped, nothing comes back
    step_dot(16'hFFFF);
    drain();

    // extreme moduli, last dot column, cookie-cut minterm, single-dot mode,
    // y-major going right so the dot wraps the d pointer past its top
    load_config(bld_cfg_t'{control0: 16'hF1CA, control1: 16'h0002, a_modulo: 16'h7FFF,
                           b_modulo: 16'h8000, c_modulo: 16'h8000, a_pattern: 16'hFFFF,
                           b_texture: 16'h5A5A});
    // error term overflows on the first add
    start_line('0, '1, 16'h7FFF, 10'd3);
    step_dot(16'h0000);
    step_dot(16'hFFFF);
    step_dot(16'h1234);
    // line already finished: dropped
    step_dot(16'hABCD);
    // length zero means the longest line; cut short by a fresh start
    start_line('1, '0, 16'h8000, '0);
    step_dot(16'hFFFF);
    step_dot(16'h0000);
    step_dot(16'h8001);
    start_line(ADDR_W'($urandom), ADDR_W'($urandom), 16'($urandom), 10'd1);
    step_dot(16'h00FF);

    // the other extreme: all octant bits, initial sign, full rotate, zero minterm
    // so every word stays zero, dot shift zero going left wraps downwards
    drain();
    load_config(bld_cfg_t'{control0: 16'h0000, control1: 16'hFFFF, a_modulo: 16'h8000,
                           b_modulo: 16'h7FFF, c_modulo: 16'h7FFF, a_pattern: 16'h0000,
                           b_texture: 16'h0000});
    start_line('0, '0, 16'h0000, 10'd2);
    step_dot(16'hFFFF);
    step_dot(16'h0000);

    // all-ones control0, plain octant, longest explicit length cut short
    drain();
    load_config(bld_cfg_t'{control0: 16'hFFFF, control1: 16'h0000, a_modulo: 16'h0000,
                           b_modulo: 16'h0000, c_modulo: 16'h0000, a_pattern: 16'h8000,
                           b_texture: 16'hFFFF});
    start_line('1, '1, 16'hFFFF, '1);
    step_dot(16'h0F0F);
    step_dot(16'hF0F0);
    start_line(ADDR_W'($urandom), ADDR_W'($urandom), 16'($urandom), 10'd1);
    step_dot(16'h0000);

    // ---- random part ----
    // three idling modes, three register settings each
    for (int mode = 0; mode < 3; mode++) begin
      send_gap_pct   = (mode == 0) ? 38 : (mode == 1) ? 49 : 0;
      recv_stall_pct = (mode == 0) ? 49 : (mode == 1) ? 38 : 0;
      for (int ph = 0; ph < 3; ph++) begin
        drain();
        cfg.control0 = 16'($urandom);
        cfg.control1 = 16'($urandom);
        if ($urandom_range(1)) begin
          cfg.a_modulo = 16'($urandom);
          cfg.b_modulo = 16'($urandom);
          cfg.c_modulo = 16'($urandom);
        end else begin
          // plausible line set-up: negative a step, positive b step, modest stride
          cfg.a_modulo = 16'(-int'($urandom_range(64)));
          cfg.b_modulo = 16'($urandom_range(64));
          cfg.c_modulo = 16'(int'($urandom_range(200)) - 100);
        end
        cfg.a_pattern = $urandom_range(1) ? 16'($urandom) : A_PATTERN_RESET;
        cfg.b_texture = 16'($urandom);
        load_config(cfg);

        goal   = taken_words + 50;
        paused = 1'b0;
        while (taken_words < goal) begin
          // halfway through, hold the sender until the result side has caught up
          if (!paused && taken_words + 25 >= goal) begin
            drain();
            paused = 1'b1;
          end
          if ($urandom_range(99) < 85) begin
            // mostly short whole lines, now and then a long one cut short
            len  = ($urandom_range(6) == 0) ? LEN_W'($urandom) : LEN_W'($urandom_range(12, 1));
            dots = (len == '0) ? (1 << LEN_W) : len;
            if (dots > 12) dots = $urandom_range(8, 1);
            else if ($urandom_range(4) == 0) dots += $urandom_range(2, 1);
            start_line(ADDR_W'($urandom), ADDR_W'($urandom), 16'($urandom), len);
            repeat (dots) step_dot(16'($urandom));
          end else begin
            // stray word of either kind
            send_word(bld_op_e'($urandom_range(1)), ADDR_W'($urandom), ADDR_W'($urandom),
                      16'($urandom), LEN_W'($urandom), 16'($urandom));
          end
        end
      end
    end

    // let everything come back, then idle on for stray words
    drain();
    repeat (8) @(negedge clk_i);

    if (ledger.errors == 0 && ledger.pending() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/bld_pkg.sv
rtl/bld_cfg_regs.sv
rtl/bld_step.sv
rtl/blitter_line_draw_stepper.sv
sim/line_write_ledger_pkg.sv
sim/testbench.sv
